// ===== src/fisr_pkg.sv =====
// Shared types, constants and single-precision arithmetic helpers for the
// fast inverse square root unit. No dependencies.
`timescale 1ns / 1ps

package fisr_pkg;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_RSQRT_TWO = 2'd0,
        OP_RSQRT_ONE = 2'd1,
        OP_SQRT_TWO  = 2'd2,
        OP_SQRT_ONE  = 2'd3
    } opcode_t;

    localparam logic [31:0] MAGIC_SEED    = 32'h5f3759df;
    localparam logic [31:0] HALF_BITS     = 32'h3f000000;
    localparam logic [31:0] ONE_HALF_BITS = 32'h3fc00000;
    localparam logic [31:0] CANON_NAN     = 32'h7fc00000;

    // Data that travels beside each item through the arithmetic chain.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] v;   // operand
        logic [31:0] x;   // operand times one half
        logic [31:0] y;   // current estimate
        logic [31:0] t;   // Newton step temporary
        logic [31:0] y1;  // estimate after the first Newton step
    } side_t;

    // Unrounded result: value = mant * 2^(k - 150), or a special value.
    typedef struct packed {
        logic               special;
        logic [31:0]        sval;
        logic               sign;
        logic signed [10:0] k;
        logic [49:0]        mant;
    } norm_t;

    // Normalized result ahead of rounding.
    typedef struct packed {
        logic               special;
        logic [31:0]        sval;
        logic               sign;
        logic               zero;
        logic signed [11:0] e;
        logic [23:0]        m;
        logic               guard;
        logic               sticky;
    } rnd_t;

    // Front half of a single-precision multiply a * b.
    function automatic norm_t mul_pre(logic [31:0] a, logic [31:0] b);
        norm_t      r;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = !(|a[30:0]);
        b_zero = !(|b[30:0]);
        r.sign = a[31] ^ b[31];
        r.k    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd150;
        r.mant = {2'b00, 48'(ma) * 48'(mb)};
        r.special = 1'b0;
        r.sval    = CANON_NAN;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            r.special = 1'b1;
        end
        else if (a_inf || b_inf) begin
            r.special = 1'b1;
            r.sval    = {r.sign, 8'hff, 23'd0};
        end
        return r;
    endfunction

    // Front half of a single-precision subtract a - b: alignment and add.
    function automatic norm_t sub_pre(logic [31:0] a, logic [31:0] b);
        norm_t       r;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic        sa;
        logic        sb;
        logic        swap;
        logic [7:0]  ebig;
        logic [7:0]  d;
        logic [4:0]  dsh;
        logic [26:0] mbig;
        logic [26:0] msml;
        logic [58:0] wide;
        logic [26:0] alg;
        logic        sbig;
        logic        ssml;
        logic [27:0] sum;
        logic a_nan, b_nan, a_inf, b_inf;
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma    = {|a[30:23], a[22:0]};
        mb    = {|b[30:23], b[22:0]};
        sa    = a[31];
        sb    = ~b[31];
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        a_inf = (&a[30:23]) && !(|a[22:0]);
        b_inf = (&b[30:23]) && !(|b[22:0]);
        // Order the operands by magnitude.
        swap = {eb, mb} > {ea, ma};
        ebig = swap ? eb : ea;
        d    = swap ? (eb - ea) : (ea - eb);
        mbig = swap ? {mb, 3'b000} : {ma, 3'b000};
        msml = swap ? {ma, 3'b000} : {mb, 3'b000};
        sbig = swap ? sb : sa;
        ssml = swap ? sa : sb;
        dsh  = (d > 8'd31) ? 5'd31 : d[4:0];
        // Align the smaller operand, folding lost bits into a sticky bit.
        wide = {msml, 32'd0} >> dsh;
        alg  = {wide[58:33], wide[32] | (|wide[31:0])};
        if (sbig ^ ssml) begin
            sum = {1'b0, mbig} - {1'b0, alg};
        end
        else begin
            sum = {1'b0, mbig} + {1'b0, alg};
        end
        r.sign = (sum == 28'd0) ? (sa & sb) : sbig;
        r.k    = $signed({3'b000, ebig}) - 11'sd3;
        r.mant = {22'd0, sum};
        r.special = 1'b0;
        r.sval    = CANON_NAN;
        if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
            r.special = 1'b1;
        end
        else if (a_inf) begin
            r.special = 1'b1;
            r.sval    = a;
        end
        else if (b_inf) begin
            r.special = 1'b1;
            r.sval    = {sb, b[30:0]};
        end
        return r;
    endfunction

    // Leading-one search and shift into 24-bit significand position.
    function automatic rnd_t normalize(norm_t n);
        rnd_t               r;
        logic [5:0]         lead;
        logic signed [11:0] d1;
        logic signed [11:0] d2;
        logic signed [11:0] sh;
        logic signed [11:0] nsh;
        logic [5:0]         rsh;
        logic [113:0]       wide;
        lead = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (n.mant[i]) begin
                lead = 6'(i);
            end
        end
        d1 = $signed({6'd0, lead}) - 12'sd23;
        d2 = 12'sd1 - $signed({n.k[10], n.k});
        sh = (d1 > d2) ? d1 : d2;
        r.special = n.special;
        r.sval    = n.sval;
        r.sign    = n.sign;
        r.zero    = (n.mant == 50'd0);
        r.e       = $signed({n.k[10], n.k}) + sh;
        nsh       = -sh;
        wide      = 114'd0;
        rsh       = 6'd0;
        if (sh < 12'sd0) begin
            r.m      = n.mant[23:0] << nsh[4:0];
            r.guard  = 1'b0;
            r.sticky = 1'b0;
        end
        else begin
            rsh      = (sh > 12'sd63) ? 6'd63 : sh[5:0];
            wide     = {n.mant, 64'd0} >> rsh;
            r.m      = wide[87:64];
            r.guard  = wide[63];
            r.sticky = |wide[62:0];
        end
        return r;
    endfunction

    // Round to nearest even and pack.
    function automatic logic [31:0] round_pack(rnd_t r);
        logic [31:0]        res;
        logic               inc;
        logic [24:0]        m25;
        logic [23:0]        m2;
        logic signed [11:0] e2;
        inc = r.guard & (r.sticky | r.m[0]);
        m25 = {1'b0, r.m} + {24'd0, inc};
        if (m25[24]) begin
            m2 = m25[24:1];
            e2 = r.e + 12'sd1;
        end
        else begin
            m2 = m25[23:0];
            e2 = r.e;
        end
        if (r.special) begin
            res = r.sval;
        end
        else if (r.zero) begin
            res = {r.sign, 31'd0};
        end
        else if (m2[23]) begin
            if (e2 >= 12'sd255) begin
                res = {r.sign, 8'hff, 23'd0};
            end
            else begin
                res = {r.sign, e2[7:0], m2[22:0]};
            end
        end
        else begin
            res = {r.sign, 8'd0, m2[22:0]};
        end
        return res;
    endfunction

endpackage

// ===== src/fisr_fp_op.sv =====
// One pipelined single-precision multiply or subtract, three stages deep,
// with a side record carried alongside. Depends on fisr_pkg.
`timescale 1ns / 1ps

module fisr_fp_op #(
    parameter bit IS_SUB = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [31:0]     a,
    input  logic [31:0]     b,
    input  fisr_pkg::side_t side_in,
    output logic            out_valid,
    output logic [31:0]     res,
    output fisr_pkg::side_t side_out
);
    import fisr_pkg::*;

    norm_t       pre_next;
    norm_t       pre_reg;
    rnd_t        nrm_next;
    rnd_t        nrm_reg;
    logic [31:0] res_next;
    logic [31:0] res_reg;
    side_t       side1_reg;
    side_t       side2_reg;
    side_t       side3_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;

    // First stage: product or aligned sum.
    generate
        if (IS_SUB) begin : g_sub
            assign pre_next = sub_pre(a, b);
        end
        else begin : g_mul
            assign pre_next = mul_pre(a, b);
        end
    endgenerate

    // Second stage: normalize. Third stage: round and pack.
    assign nrm_next = normalize(pre_reg);
    assign res_next = round_pack(nrm_reg);

    // Valid bits advance with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg   <= pre_next;
            nrm_reg   <= nrm_next;
            res_reg   <= res_next;
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;
    assign side_out  = side3_reg;

endmodule

// ===== src/fast_inverse_square_root_unit.sv =====
// Top level of the fast inverse square root unit: bit-trick seed, Newton
// steps and optional square-root multiply. Depends on fisr_pkg, fisr_fp_op.
`timescale 1ns / 1ps

// The unit accepts one item per clock cycle while the pipeline is not held;
// ten single-precision operations (operand halving, two Newton steps
// of four operations each, and the final multiply by the operand) each take
// three register stages. Every item passes through all ten; the operation
// code only selects which intermediate becomes the result. When the output
// item is not taken, the whole pipeline holds, so in_ready follows out_ready
// whenever an item waits at the output. Any NaN result is returned as the
// canonical quiet NaN 0x7fc00000.
module fast_inverse_square_root_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits
);
    import fisr_pkg::*;

    logic        en;
    logic [31:0] seed;
    side_t       sd    [0:9];
    side_t       so    [1:10];
    logic [31:0] ra    [1:10];
    logic [31:0] rb    [1:10];
    logic [31:0] r     [1:10];
    logic        vld   [0:10];
    logic [31:0] final_bits;

    // The pipeline advances unless a finished item is held at the output.
    assign en       = !vld[10] || out_ready;
    assign in_ready = en;

    // First guess from the integer view of the operand.
    assign seed  = MAGIC_SEED - {operand_bits[31], operand_bits[31:1]};
    assign vld[0] = in_valid;
    assign sd[0]  = '{op: operation, v: operand_bits, x: 32'd0, y: seed,
                      t: 32'd0, y1: 32'd0};

    // Operand selection for each arithmetic step.
    assign ra[1]  = sd[0].v;   assign rb[1]  = HALF_BITS;
    assign ra[2]  = sd[1].x;   assign rb[2]  = sd[1].y;
    assign ra[3]  = sd[2].t;   assign rb[3]  = sd[2].y;
    assign ra[4]  = ONE_HALF_BITS; assign rb[4] = sd[3].t;
    assign ra[5]  = sd[4].y;   assign rb[5]  = sd[4].t;
    assign ra[6]  = sd[5].x;   assign rb[6]  = sd[5].y;
    assign ra[7]  = sd[6].t;   assign rb[7]  = sd[6].y;
    assign ra[8]  = ONE_HALF_BITS; assign rb[8] = sd[7].t;
    assign ra[9]  = sd[8].y;   assign rb[9]  = sd[8].t;
    assign ra[10] = sd[9].v;   assign rb[10] = sd[9].y;

    // Write-back of each step's result into the side record.
    always_comb
    begin
        sd[1]    = so[1];
        sd[1].x  = r[1];
        sd[2]    = so[2];
        sd[2].t  = r[2];
        sd[3]    = so[3];
        sd[3].t  = r[3];
        sd[4]    = so[4];
        sd[4].t  = r[4];
        sd[5]    = so[5];
        sd[5].y  = r[5];
        sd[5].y1 = r[5];
        sd[6]    = so[6];
        sd[6].t  = r[6];
        sd[7]    = so[7];
        sd[7].t  = r[7];
        sd[8]    = so[8];
        sd[8].t  = r[8];
        // One-step codes keep the estimate from the first Newton step.
        sd[9]    = so[9];
        sd[9].y  = so[9].op[0] ? so[9].y1 : r[9];
    end

    // Arithmetic chain: steps four and eight subtract, all others multiply.
    generate
        for (genvar i = 1; i <= 10; i++) begin : g_step
            fisr_fp_op #(
                .IS_SUB ((i == 4) || (i == 8))
            ) u_op (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (vld[i-1]),
                .a         (ra[i]),
                .b         (rb[i]),
                .side_in   (sd[i-1]),
                .out_valid (vld[i]),
                .res       (r[i]),
                .side_out  (so[i])
            );
        end
    endgenerate

    // Square-root codes take the product with the operand.
    assign final_bits = so[10].op[1] ? r[10] : so[10].y;

    // Any NaN leaves as the canonical quiet NaN.
    assign result_bits = ((&final_bits[30:23]) && (|final_bits[22:0])) ?
                         CANON_NAN : final_bits;
    assign out_valid   = vld[10];

endmodule

// ===== tb/fisr_checker.sv =====
// Scoreboard for the fast inverse square root unit: watches both channels,
// predicts each result with its own single-precision arithmetic and compares.
// Depends on fisr_pkg for the operation codes and constants.
`timescale 1ns / 1ps

module fisr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] operand_bits,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] result_bits,
    output int          error_count,
    output int          pending_count,
    output int          checked_count
);
    import fisr_pkg::*;

    logic [31:0] expected_results[$];

    // Rounds the exact value sig * 2^scale to single precision, nearest even.
    function automatic logic [31:0] round_single(logic sign, logic [63:0] sig, int scale);
        int           lead;
        int           biased;
        int           sh;
        int           base;
        logic [127:0] wide;
        logic [63:0]  keep;
        logic         guard;
        logic         sticky;
        logic [63:0]  packed_mag;
        if (sig == 64'd0)
        begin
            return {sign, 31'd0};
        end
        lead = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (sig[i])
            begin
                lead = i;
            end
        end
        biased = lead + scale + 127;
        sh     = lead - 23 + ((biased < 1) ? (1 - biased) : 0);
        base   = (biased < 1) ? 1 : biased;
        if (sh <= 0)
        begin
            keep   = sig << (-sh);
            guard  = 1'b0;
            sticky = 1'b0;
        end
        else
        begin
            wide   = {sig, 64'd0} >> ((sh > 127) ? 127 : sh);
            keep   = wide[127:64];
            guard  = (sh > 127) ? 1'b0 : wide[63];
            sticky = (sh > 127) ? 1'b1 : (|wide[62:0]);
        end
        if (guard && (sticky || keep[0]))
        begin
            keep = keep + 64'd1;
        end
        // A carry out of the significand moves into the exponent field.
        packed_mag = (64'(base - 1) << 23) + keep;
        if (packed_mag >= 64'h7f800000)
        begin
            return {sign, 8'hff, 23'd0};
        end
        return {sign, packed_mag[30:0]};
    endfunction

    function automatic logic is_nan(logic [31:0] f);
        return (&f[30:23]) && (|f[22:0]);
    endfunction

    function automatic logic is_inf(logic [31:0] f);
        return (&f[30:23]) && !(|f[22:0]);
    endfunction

    function automatic logic [23:0] significand(logic [31:0] f);
        return {|f[30:23], f[22:0]};
    endfunction

    function automatic int exponent_of(logic [31:0] f);
        return (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
    endfunction

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
        logic sign;
        sign = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && b[30:0] == 31'd0)
            || (is_inf(b) && a[30:0] == 31'd0))
        begin
            return CANON_NAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {sign, 8'hff, 23'd0};
        end
        return round_single(sign, 64'(significand(a)) * 64'(significand(b)),
                            exponent_of(a) + exponent_of(b) - 300);
    endfunction

    // Subtract a - b as an add of a and the negated b.
    function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b_in);
        logic [31:0] b;
        logic [31:0] big;
        logic [31:0] sml;
        int          exp_gap;
        logic [63:0] big_w;
        logic [63:0] sml_w;
        logic [63:0] total;
        logic        lost;
        b = {~b_in[31], b_in[30:0]};
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31]))
        begin
            return CANON_NAN;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if ({exponent_of(b), significand(b)} > {exponent_of(a), significand(a)})
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        exp_gap = exponent_of(big) - exponent_of(sml);
        big_w   = 64'(significand(big)) << 30;
        if (exp_gap >= 64)
        begin
            sml_w = 64'd0;
            lost  = |significand(sml);
        end
        else
        begin
            sml_w = (64'(significand(sml)) << 30) >> exp_gap;
            lost  = ((sml_w << exp_gap) != (64'(significand(sml)) << 30));
        end
        sml_w[0] = sml_w[0] | lost;
        total = (big[31] == sml[31]) ? (big_w + sml_w) : (big_w - sml_w);
        if (total == 64'd0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        return round_single(big[31], total, exponent_of(big) - 180);
    endfunction

    function automatic logic [31:0] newton_refine(logic [31:0] est, logic [31:0] half_val);
        return fmul(est, fsub(ONE_HALF_BITS, fmul(fmul(half_val, est), est)));
    endfunction

    function automatic logic [31:0] predict_root(opcode_t op, logic [31:0] value);
        logic [31:0] half_val;
        logic [31:0] est;
        logic [31:0] res;
        half_val = fmul(value, HALF_BITS);
        est      = MAGIC_SEED - {value[31], value[31:1]};
        est      = newton_refine(est, half_val);
        if (op == OP_RSQRT_TWO || op == OP_SQRT_TWO)
        begin
            est = newton_refine(est, half_val);
        end
        res = (op == OP_SQRT_TWO || op == OP_SQRT_ONE) ? fmul(value, est) : est;
        return is_nan(res) ? CANON_NAN : res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %08h want %08h", $realtime, what, got, want);
        error_count++;
    endtask

    assign pending_count = expected_results.size();

    // Predict on each accepted input item, compare on each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            expected_results.delete();
            error_count   <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_root(opcode_t'(operation), operand_bits));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", result_bits, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bits !== want)
                    begin
                        report_mismatch("result_bits", result_bits, want);
                    end
                    checked_count <= checked_count + 1;
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the fast inverse square root unit testbench: clock, reset, stimulus
// and verdict. Depends on fisr_pkg, fast_inverse_square_root_unit, fisr_checker.
`timescale 1ns / 1ps

module testbench;
    import fisr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_bits;

    int error_count;
    int pending_count;
    int checked_count;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int quiet_cycles;

    fast_inverse_square_root_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .operand_bits(operand_bits),
        .out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
    );

    fisr_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .operand_bits(operand_bits),
        .out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits),
        .error_count(error_count), .pending_count(pending_count),
        .checked_count(checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at the rate set for the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(opcode_t op, logic [31:0] value);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        operand_bits <= value;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly positive normals with biased exponents 54 to 200, otherwise any bit pattern.
    function automatic logic [31:0] random_operand();
        logic [31:0] value;
        if ($urandom_range(9) < 6)
        begin
            value = {1'b0, 8'($urandom_range(200, 54)), 23'($urandom)};
        end
        else
        begin
            value = $urandom;
        end
        return value;
    endfunction

    logic [31:0] corner_values[16] = '{
        32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
        32'h7fc00000, 32'h7f800001, 32'h3f800000, 32'hbf800000,
        32'h40800000, 32'h00000001, 32'h007fffff, 32'h00800000,
        32'h7f7fffff, 32'h80000001, 32'hffffffff, 32'h7fffffff
    };

    initial
    begin
        int idle_modes[4];
        int stall_modes[4];
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_RSQRT_TWO;
        operand_bits   = 32'd0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        quiet_cycles   = 0;
        idle_modes     = '{0, 54, 0, 22};
        stall_modes    = '{0, 0, 54, 22};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: zeros, infinities, NaNs, subnormals, extremes.
        for (int i = 0; i < 24; i++)
        begin
            send_item(opcode_t'(i % 4), corner_values[(i * 5) % 16]);
        end
        send_item(OP_SQRT_ONE, 32'h55555555);
        wait_drained();

        // Random phases with different idling on each side.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_modes[phase];
            recv_stall_pct = stall_modes[phase];
            for (int n = 0; n < 285; n++)
            begin
                send_item(opcode_t'($urandom_range(3)), random_operand());
                if (n == 140)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items over four idling phases; %0d results checked.",
                 items_sent, checked_count);
        $display("Covered all four operations, special values and random operands.");
        if (error_count == 0 && pending_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
